@@ hdl/ibpo_pkg.sv @@
// ----------------------------------------------------------------------------
// ibpo_pkg
// Types and constants shared by the indicator blink/pulse opacity block.
// ----------------------------------------------------------------------------
package ibpo_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   // indicator modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_BLINK = 2'd2;
   localparam logic [1:0] MODE_PULSE = 2'd3;

   // configuration register indexes
   localparam logic CSR_ICON_COUNT = 1'b0;
   localparam logic CSR_BOOT_CHECK = 1'b1;

   localparam logic [15:0] BOOT_DEFAULT = 16'd2000;
   localparam int          MAX_OUT      = 16;

   // opacity constants
   localparam logic [7:0] OPA_OFF   = 8'd0;
   localparam logic [7:0] OPA_FULL  = 8'd255;
   localparam logic [7:0] PULSE_MIN = 8'd90;

   // time base: t/250 taken as (t>>1)/125, one hex digit per step
   localparam int BLINK_DIV    = 125;
   localparam int DIV_STEPS    = 8;
   localparam int BLINK_MS     = 250;
   localparam int PULSE_PERIOD = 1000;
   localparam int PULSE_HALF   = 500;
   // floor(165*u/500) = (u * 33 * 5243) >> 19 for u up to 500
   localparam int PULSE_RECIP  = 173019;
   localparam int PULSE_SHIFT  = 19;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [3:0] icon_idx_type;

   typedef struct packed {
      logic [1:0]   command;
      logic [31:0]  now_ms;
      icon_idx_type icon_index;
      logic [1:0]   new_mode;
   } req_type;

   typedef struct packed {
      icon_idx_type out_index;
      logic [7:0]   opacity;
      logic         last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic         is_tick;
      logic         boot;
      logic         blink_high;
      logic [7:0]   pulse;
      icon_idx_type icon_index;
      logic [1:0]   new_mode;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_LEVEL,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FLUSH
   } back_state_type;

endpackage

@@ hdl/ibpo_front.sv @@
// ----------------------------------------------------------------------------
// ibpo_front
// Accepts commands, keeps the start time and works out the tick time base.
// ----------------------------------------------------------------------------
module ibpo_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ibpo_pkg::req_type      req_payload,
   input  logic [15:0]            boot_window,
   input  ibpo_pkg::fifo_stat_type q_stat,
   output logic                   push_valid,
   output ibpo_pkg::cmd_type      push_data
);

   function automatic logic [3:0] div125_digit(input logic [10:0] v);
      logic [3:0] d;
      d = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (v >= 11'(k * ibpo_pkg::BLINK_DIV)) d = 4'(k);
      end
      return d;
   endfunction

   ibpo_pkg::front_state_type state_ff, state_in;
   logic [31:0] start_time_ff, start_time_in;
   logic        boot_ff, boot_in;
   logic [31:0] div_x_ff, div_x_in;
   logic [6:0]  rem_ff, rem_in;
   logic [1:0]  q_lo_ff, q_lo_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        t0_ff, t0_in;
   logic [7:0]  pulse_ff, pulse_in;
   logic        blink_ff, blink_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibpo_pkg::FR_IDLE;
         start_time_ff <= 32'd0;
      end else begin
         state_ff      <= state_in;
         start_time_ff <= start_time_in;
      end
      boot_ff  <= boot_in;
      div_x_ff <= div_x_in;
      rem_ff   <= rem_in;
      q_lo_ff  <= q_lo_in;
      cnt_ff   <= cnt_in;
      t0_ff    <= t0_in;
      pulse_ff <= pulse_in;
      blink_ff <= blink_in;
   end

   always_comb begin
      logic [31:0] start_eff;
      logic [31:0] since;
      logic [10:0] nxt;
      logic [3:0]  d;
      logic [7:0]  tm250;
      logic [9:0]  p;
      logic [8:0]  u;
      logic [26:0] prod;

      state_in      = state_ff;
      start_time_in = start_time_ff;
      boot_in       = boot_ff;
      div_x_in      = div_x_ff;
      rem_in        = rem_ff;
      q_lo_in       = q_lo_ff;
      cnt_in        = cnt_ff;
      t0_in         = t0_ff;
      pulse_in      = pulse_ff;
      blink_in      = blink_ff;

      start_eff = (start_time_ff == 32'd0) ? req_payload.now_ms : start_time_ff;
      since     = req_payload.now_ms - start_eff;
      nxt       = {rem_ff, div_x_ff[31:28]};
      d         = div125_digit(nxt);
      tm250     = {rem_ff, t0_ff};
      p         = 10'(int'(q_lo_ff) * ibpo_pkg::BLINK_MS) + {2'b00, tm250};
      u         = (p < 10'(ibpo_pkg::PULSE_HALF)) ? p[8:0]
                                                  : 9'(10'(ibpo_pkg::PULSE_PERIOD) - p);
      prod      = 27'(u) * 27'(ibpo_pkg::PULSE_RECIP);

      req_ready  = (state_ff == ibpo_pkg::FR_IDLE) && !q_stat.full;
      push_valid = 1'b0;
      push_data.is_tick    = 1'b1;
      push_data.boot       = boot_ff;
      push_data.blink_high = blink_ff;
      push_data.pulse      = pulse_ff;
      push_data.icon_index = req_payload.icon_index;
      push_data.new_mode   = req_payload.new_mode;

      case (state_ff)
         ibpo_pkg::FR_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_payload.command)
                  ibpo_pkg::CMD_TICK: begin
                     start_time_in = start_eff;
                     boot_in       = since < {16'd0, boot_window};
                     div_x_in      = {1'b0, req_payload.now_ms[31:1]};
                     t0_in         = req_payload.now_ms[0];
                     rem_in        = 7'd0;
                     cnt_in        = 3'd0;
                     state_in      = ibpo_pkg::FR_DIV;
                  end
                  ibpo_pkg::CMD_SET: begin
                     push_valid        = 1'b1;
                     push_data.is_tick = 1'b0;
                  end
                  ibpo_pkg::CMD_START: begin
                     start_time_in = req_payload.now_ms;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ibpo_pkg::FR_DIV: begin
            rem_in   = 7'(nxt - 11'(int'(d) * ibpo_pkg::BLINK_DIV));
            q_lo_in  = d[1:0];
            div_x_in = {div_x_ff[27:0], 4'd0};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'(ibpo_pkg::DIV_STEPS - 1)) state_in = ibpo_pkg::FR_LEVEL;
         end
         ibpo_pkg::FR_LEVEL: begin
            pulse_in = ibpo_pkg::PULSE_MIN + prod[ibpo_pkg::PULSE_SHIFT +: 8];
            blink_in = !q_lo_ff[0];
            state_in = ibpo_pkg::FR_PUSH;
         end
         ibpo_pkg::FR_PUSH: begin
            if (!q_stat.full) begin
               push_valid = 1'b1;
               state_in   = ibpo_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = ibpo_pkg::FR_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ibpo_queue.sv @@
// ----------------------------------------------------------------------------
// ibpo_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ibpo_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  ibpo_pkg::cmd_type       push_data,
   input  logic                    pop,
   output ibpo_pkg::cmd_type       pop_data,
   output ibpo_pkg::fifo_stat_type q_stat
);

   localparam int CNT_W = $clog2(ibpo_pkg::QUEUE_DEPTH + 1);

   ibpo_pkg::cmd_type entry_ff [ibpo_pkg::QUEUE_DEPTH];
   logic [ibpo_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ibpo_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(ibpo_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push_valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ibpo_pkg::QPTR_W'(ibpo_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ibpo_pkg::QPTR_W'(ibpo_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ hdl/ibpo_back.sv @@
// ----------------------------------------------------------------------------
// ibpo_back
// Applies mode writes and walks the indicators on each tick, one per cycle while rsp does not stall.
// ----------------------------------------------------------------------------
module ibpo_back #(
   parameter int NUM_INDICATORS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              icon_count,
   input  ibpo_pkg::fifo_stat_type q_stat,
   output logic                    pop,
   input  ibpo_pkg::cmd_type       pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ibpo_pkg::rsp_type       rsp_payload
);

   localparam int DEPTH = (NUM_INDICATORS < ibpo_pkg::MAX_OUT) ? NUM_INDICATORS
                                                                : ibpo_pkg::MAX_OUT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ibpo_pkg::back_state_type state_ff, state_in;
   logic [1:0]       mode_ff [DEPTH];
   logic [7:0]       last_ff [DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             boot_ff, boot_in;
   logic             blink_ff, blink_in;
   logic [7:0]       pulse_ff, pulse_in;
   logic             pend_valid_ff, pend_valid_in;
   ibpo_pkg::icon_idx_type pend_idx_ff, pend_idx_in;
   logic [7:0]       pend_opa_ff, pend_opa_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ibpo_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic             mode_we;
   logic [IDX_W-1:0] mode_wa;
   logic             last_we;
   logic [IDX_W-1:0] scan_idx;
   logic [1:0]       scan_mode;
   logic [7:0]       scan_opa;
   logic             out_free;

   assign scan_idx    = cnt_ff[IDX_W-1:0];
   assign scan_mode   = boot_ff ? ibpo_pkg::MODE_ON : mode_ff[scan_idx];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign mode_wa     = pop_data.icon_index[IDX_W-1:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      case (scan_mode)
         ibpo_pkg::MODE_OFF:   scan_opa = ibpo_pkg::OPA_OFF;
         ibpo_pkg::MODE_ON:    scan_opa = ibpo_pkg::OPA_FULL;
         ibpo_pkg::MODE_BLINK: scan_opa = blink_ff ? ibpo_pkg::OPA_FULL : ibpo_pkg::OPA_OFF;
         default:              scan_opa = pulse_ff;
      endcase
   end

   always_comb begin
      logic chg;
      logic advance;

      state_in       = state_ff;
      cnt_in         = cnt_ff;
      n_in           = n_ff;
      boot_in        = boot_ff;
      blink_in       = blink_ff;
      pulse_in       = pulse_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_opa_in    = pend_opa_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      mode_we        = 1'b0;
      last_we        = 1'b0;

      chg     = (scan_opa != last_ff[scan_idx]);
      advance = !chg || !pend_valid_ff || out_free;

      case (state_ff)
         ibpo_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               pop = 1'b1;
               if (pop_data.is_tick) begin
                  boot_in  = pop_data.boot;
                  blink_in = pop_data.blink_high;
                  pulse_in = pop_data.pulse;
                  cnt_in   = '0;
                  n_in     = (int'(icon_count) > DEPTH) ? CNT_W'(DEPTH)
                                                        : CNT_W'(icon_count);
                  if (n_in != '0) state_in = ibpo_pkg::BK_SCAN;
               end else begin
                  mode_we = (int'(pop_data.icon_index) < DEPTH);
               end
            end
         end
         ibpo_pkg::BK_SCAN: begin
            if (chg && advance) begin
               last_we = 1'b1;
               if (pend_valid_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_payload_in.out_index    = pend_idx_ff;
                  rsp_payload_in.opacity      = pend_opa_ff;
                  rsp_payload_in.last_of_tick = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_idx_in   = ibpo_pkg::icon_idx_type'(scan_idx);
               pend_opa_in   = scan_opa;
            end
            if (advance) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_in == n_ff) state_in = ibpo_pkg::BK_FLUSH;
            end
         end
         ibpo_pkg::BK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ibpo_pkg::BK_IDLE;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.out_index    = pend_idx_ff;
               rsp_payload_in.opacity      = pend_opa_ff;
               rsp_payload_in.last_of_tick = 1'b1;
               pend_valid_in               = 1'b0;
               state_in                    = ibpo_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ibpo_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibpo_pkg::BK_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            mode_ff[i] <= ibpo_pkg::MODE_OFF;
            last_ff[i] <= ibpo_pkg::OPA_OFF;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mode_we) mode_ff[mode_wa] <= pop_data.new_mode;
         if (last_we) last_ff[scan_idx] <= scan_opa;
      end
      cnt_ff         <= cnt_in;
      n_ff           <= n_in;
      boot_ff        <= boot_in;
      blink_ff       <= blink_in;
      pulse_ff       <= pulse_in;
      pend_idx_ff    <= pend_idx_in;
      pend_opa_ff    <= pend_opa_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_pend_not_idle: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff != ibpo_pkg::BK_IDLE)
      else $error("pending change left behind in idle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ibpo_pkg::BK_SCAN |-> cnt_ff < n_ff && n_ff != '0)
      else $error("scan counter out of range");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibpo_pkg::BK_FLUSH && pend_valid_ff && out_free)
      |=> rsp_valid_ff && rsp_payload_ff.last_of_tick)
      else $error("final beat of tick not marked last");

endmodule

@@ hdl/indicator_blink_pulse_opacity.sv @@
// ----------------------------------------------------------------------------
// indicator_blink_pulse_opacity
// Opacity controller for blinking and pulsing indicators.
//
// The req channel takes tick, set-mode and start commands (valid/ready).
// Set, start and the unused code are done in the front's idle state. A
// tick holds the front while it is accepted, run through the hex-digit
// divider that splits the time into blink phase and pulse position, made
// into a pulse level and queued. The back pops a tick from the queue,
// walks n = min(icon_count, NUM_INDICATORS, 16) indicators one per cycle
// while rsp does not stall, and ends in a flush state. A change is held
// until the next change is found or the scan ends, then sent as one rsp
// beat; the last beat is marked last_of_tick. A four-entry queue parts
// front and back, so commands keep flowing while the back scans. When rsp
// stalls, the scan holds on the next change and the queue fills before
// req_ready drops.
// Reset clears the start time, all modes (off), all opacities (0),
// icon_count to 0 and the boot window to 2000. csr_we writes register
// csr_index: 0 icon_count, 1 boot window; write only while idle.
// ----------------------------------------------------------------------------
module indicator_blink_pulse_opacity #(
   parameter int NUM_INDICATORS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ibpo_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ibpo_pkg::rsp_type  rsp_payload,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [4:0]  icon_count_ff;
   logic [15:0] boot_check_ff;

   logic                    push_valid;
   ibpo_pkg::cmd_type       push_data;
   logic                    pop;
   ibpo_pkg::cmd_type       pop_data;
   ibpo_pkg::fifo_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         icon_count_ff <= 5'd0;
         boot_check_ff <= ibpo_pkg::BOOT_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            ibpo_pkg::CSR_ICON_COUNT: icon_count_ff <= csr_wdata[4:0];
            ibpo_pkg::CSR_BOOT_CHECK: boot_check_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ibpo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .boot_window (boot_check_ff),
      .q_stat      (q_stat),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   ibpo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .q_stat     (q_stat)
   );

   ibpo_back #(
      .NUM_INDICATORS (NUM_INDICATORS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .icon_count  (icon_count_ff),
      .q_stat      (q_stat),
      .pop         (pop),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the indicator blink/pulse opacity controller.
//
// Drives tick, set-mode and start commands on req with random gaps. A
// predictor keeps the start time, the mode and the last opacity of every
// indicator, and queues the opacity changes each tick should report. Every
// rsp beat is checked field by field against the oldest queued change.
// Directed tests cover the power-up state, each mode at its blink and pulse
// edges, the boot window with time wrap, and icon_count clamping. A long
// rsp stall fills the block and stalls req. Random traffic follows in
// phases with different register settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          NUM_ICONS     = 16;
   localparam int          SETTLE_CYCLES = 120;
   localparam int          PHASE_ITEMS   = 72;
   localparam longint      TIMEOUT_NS    = 64'd10_000_000;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ibpo_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   ibpo_pkg::rsp_type rsp_payload;
   logic              csr_we;
   logic              csr_index;
   logic [15:0]       csr_wdata;

   // predictor state
   logic [31:0] captured_ms;
   logic [1:0]  icon_mode [NUM_ICONS];
   logic [7:0]  shown_opacity [NUM_ICONS];
   logic [4:0]  scan_count;
   logic [15:0] boot_window;

   ibpo_pkg::rsp_type pending_changes [$];
   int          mismatches = 0;
   logic [31:0] wall_ms = 32'd0;
   bit          sender_gaps = 1'b1;
   bit          sink_stalls = 1'b1;
   int          rsp_hold_cycles = 0;

   indicator_blink_pulse_opacity #(.NUM_INDICATORS(NUM_ICONS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 30);
   endfunction

   function automatic ibpo_pkg::req_type make_req(logic [1:0] cmd, logic [31:0] t,
                                                  logic [3:0] idx, logic [1:0] md);
      ibpo_pkg::req_type r;
      r.command    = cmd;
      r.now_ms     = t;
      r.icon_index = idx;
      r.new_mode   = md;
      return r;
   endfunction

   // work out which opacities change on a tick at time t
   function automatic void predict_tick(logic [31:0] t);
      int unsigned       n;
      int                last_changed;
      logic [31:0]       elapsed;
      logic [31:0]       phase_ms;
      logic [31:0]       ramp_ms;
      logic [7:0]        level;
      logic [7:0]        fresh [NUM_ICONS];
      logic              in_boot;
      logic              blink_lit;
      logic [1:0]        m;
      ibpo_pkg::rsp_type beat;
      n = scan_count;
      if (n > NUM_ICONS) n = NUM_ICONS;
      if (n > ibpo_pkg::MAX_OUT) n = ibpo_pkg::MAX_OUT;
      if (captured_ms == 32'd0) captured_ms = t;
      elapsed   = t - captured_ms;
      in_boot   = elapsed < {16'd0, boot_window};
      blink_lit = ((t / ibpo_pkg::BLINK_MS) % 2) == 0;
      phase_ms  = t % ibpo_pkg::PULSE_PERIOD;
      ramp_ms   = (phase_ms < ibpo_pkg::PULSE_HALF) ? phase_ms
                                                    : ibpo_pkg::PULSE_PERIOD - phase_ms;
      level     = 8'(ibpo_pkg::PULSE_MIN
                     + (ramp_ms * 32'(ibpo_pkg::OPA_FULL - ibpo_pkg::PULSE_MIN))
                     / ibpo_pkg::PULSE_HALF);
      last_changed = -1;
      for (int i = 0; i < n; i++) begin
         m = in_boot ? ibpo_pkg::MODE_ON : icon_mode[i];
         case (m)
            ibpo_pkg::MODE_OFF:   fresh[i] = ibpo_pkg::OPA_OFF;
            ibpo_pkg::MODE_ON:    fresh[i] = ibpo_pkg::OPA_FULL;
            ibpo_pkg::MODE_BLINK: fresh[i] = blink_lit ? ibpo_pkg::OPA_FULL : ibpo_pkg::OPA_OFF;
            default:              fresh[i] = level;
         endcase
         if (fresh[i] != shown_opacity[i]) last_changed = i;
      end
      for (int i = 0; i < n; i++) begin
         if (fresh[i] != shown_opacity[i]) begin
            shown_opacity[i]  = fresh[i];
            beat.out_index    = 4'(i);
            beat.opacity      = fresh[i];
            beat.last_of_tick = (i == last_changed);
            pending_changes.push_back(beat);
         end
      end
   endfunction

   task automatic send_item(input ibpo_pkg::req_type item);
      int unsigned gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      case (item.command)
         ibpo_pkg::CMD_TICK: begin
            predict_tick(item.now_ms);
         end
         ibpo_pkg::CMD_SET: begin
            if (item.icon_index < NUM_ICONS) icon_mode[item.icon_index] = item.new_mode;
         end
         ibpo_pkg::CMD_START: begin
            captured_ms = item.now_ms;
         end
         default: ;
      endcase
   endtask

   // wait until every queued change has come back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_changes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ibpo_pkg::CSR_ICON_COUNT) scan_count = value[4:0];
      else boot_window = value;
      @(posedge clock);
   endtask

   task automatic test_idle_count();
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd5, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 4'hF, ibpo_pkg::MODE_PULSE));
      drain();
      write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd16);
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd6, 4'd0, ibpo_pkg::MODE_OFF));
   endtask

   task automatic test_mode_levels();
      send_item(make_req(ibpo_pkg::CMD_SET, 32'd0, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_SET, 32'd0, 4'd1, ibpo_pkg::MODE_ON));
      send_item(make_req(ibpo_pkg::CMD_SET, 32'd0, 4'd2, ibpo_pkg::MODE_BLINK));
      send_item(make_req(ibpo_pkg::CMD_SET, 32'd0, 4'd3, ibpo_pkg::MODE_PULSE));
      send_item(make_req(ibpo_pkg::CMD_SET, 32'hFFFF_FFFF, 4'd15, ibpo_pkg::MODE_PULSE));
      drain();
      write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'd0);
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd249, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd250, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd500, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd501, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd999, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd1000, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'hFFFF_FFFF, 4'd0, ibpo_pkg::MODE_OFF));
   endtask

   task automatic test_boot_window();
      drain();
      write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'd3000);
      send_item(make_req(ibpo_pkg::CMD_START, 32'd100, 4'd0, ibpo_pkg::MODE_OFF));
      // start at zero is recaptured by the next tick
      send_item(make_req(ibpo_pkg::CMD_START, 32'd0, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd7000, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd9999, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd10000, 4'd0, ibpo_pkg::MODE_OFF));
      // elapsed time wraps through zero
      send_item(make_req(ibpo_pkg::CMD_START, 32'hFFFF_FF00, 4'd0, ibpo_pkg::MODE_OFF));
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'h0000_0100, 4'd0, ibpo_pkg::MODE_OFF));
   endtask

   task automatic test_count_clamp();
      drain();
      write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd31);
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd12345, 4'd0, ibpo_pkg::MODE_OFF));
      drain();
      write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd17);
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd12600, 4'd0, ibpo_pkg::MODE_OFF));
      drain();
      write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd1);
      send_item(make_req(ibpo_pkg::CMD_TICK, 32'd12750, 4'd0, ibpo_pkg::MODE_OFF));
   endtask

   task automatic test_backpressure();
      drain();
      write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd16);
      write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'd0);
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      for (int i = 0; i < NUM_ICONS; i++)
         send_item(make_req(ibpo_pkg::CMD_SET, $urandom(), 4'(i), ibpo_pkg::MODE_PULSE));
      rsp_hold_cycles = 400;
      // every tick changes all pulse levels, so the queue fills up
      for (int k = 1; k <= 12; k++)
         send_item(make_req(ibpo_pkg::CMD_TICK, 32'(20000 + 37 * k), 4'd0,
                            ibpo_pkg::MODE_OFF));
      drain();
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
   endtask

   task automatic test_random_traffic();
      int                accepted;
      int unsigned       r;
      ibpo_pkg::req_type item;
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd16);
               write_csr(ibpo_pkg::CSR_BOOT_CHECK, ibpo_pkg::BOOT_DEFAULT);
               sender_gaps = 1'b1;
               sink_stalls = 1'b1;
            end
            1: begin
               write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'($urandom_range(1, 31)));
               write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'd0);
               sender_gaps = 1'b0;
               sink_stalls = 1'b0;
            end
            2: begin
               write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'($urandom_range(0, 16)));
               write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'hFFFF);
               sender_gaps = 1'b1;
               sink_stalls = 1'b0;
            end
            default: begin
               write_csr(ibpo_pkg::CSR_ICON_COUNT, 16'd31);
               write_csr(ibpo_pkg::CSR_BOOT_CHECK, 16'($urandom_range(0, 65535)));
               sender_gaps = 1'b0;
               sink_stalls = 1'b1;
            end
         endcase
         accepted = 0;
         while (accepted < PHASE_ITEMS) begin
            item = make_req(ibpo_pkg::CMD_TICK, $urandom(), 4'($urandom_range(0, 15)),
                            2'($urandom_range(0, 3)));
            r = $urandom_range(0, 99);
            if (r < 55) begin
               r = $urandom_range(0, 99);
               if (r < 87) wall_ms += $urandom_range(1, 300);
               else if (r < 97) wall_ms += $urandom_range(0, 5000);
               else wall_ms += $urandom();
               item.now_ms = wall_ms;
            end else if (r < 85) begin
               item.command = ibpo_pkg::CMD_SET;
            end else if (r < 93) begin
               item.command = ibpo_pkg::CMD_START;
               item.now_ms  = ($urandom_range(0, 3) == 0) ? 32'd0 : wall_ms;
            end else if (r < 96) begin
               item.command = CMD_UNUSED;
            end else begin
               wall_ms = item.now_ms;
            end
            send_item(item);
            if (item.command != CMD_UNUSED) accepted++;
         end
      end
   endtask

   function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
   endfunction

   // check each accepted rsp beat against the oldest predicted change
   always @(posedge clock) begin : rsp_check
      ibpo_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_changes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none actual index %0d opacity %0d",
                     $time, rsp_payload.out_index, rsp_payload.opacity);
         end else begin
            want = pending_changes.pop_front();
            compare_field("out_index", 8'(want.out_index), 8'(rsp_payload.out_index));
            compare_field("opacity", want.opacity, rsp_payload.opacity);
            compare_field("last_of_tick", 8'(want.last_of_tick), 8'(rsp_payload.last_of_tick));
         end
      end
   end

   initial begin : rsp_sink
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : run_tests
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= ibpo_pkg::CSR_ICON_COUNT;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      captured_ms = 32'd0;
      scan_count  = 5'd0;
      boot_window = ibpo_pkg::BOOT_DEFAULT;
      for (int i = 0; i < NUM_ICONS; i++) begin
         icon_mode[i]     = ibpo_pkg::MODE_OFF;
         shown_opacity[i] = ibpo_pkg::OPA_OFF;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_count();
      test_mode_levels();
      test_boot_window();
      test_count_clamp();
      test_backpressure();
      test_random_traffic();
      drain();
      if (mismatches == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ indicator_blink_pulse_opacity.f @@
hdl/ibpo_pkg.sv
hdl/ibpo_front.sv
hdl/ibpo_queue.sv
hdl/ibpo_back.sv
hdl/indicator_blink_pulse_opacity.sv
test/tb_top.sv
